// ===== rtl/tdp_pkg.sv =====
// shared constants and types for the trial division prime test block
// no dependencies; imported by tdp_rem_unit, tdp_checker, the top level and the testbench
package tdp_pkg;

    // operand widths
    localparam int VALUE_WIDTH   = 31;
    localparam int DIV_WIDTH     = VALUE_WIDTH / 2 + 2;
    localparam int SQ_WIDTH      = 2 * DIV_WIDTH;
    localparam int CNT_WIDTH     = $clog2(VALUE_WIDTH);
    localparam int S_TDATA_WIDTH = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_WIDTH = 8;

    // first odd trial divisor and its square
    localparam logic [DIV_WIDTH-1:0] FIRST_DIVISOR = DIV_WIDTH'(3);
    localparam logic [SQ_WIDTH-1:0]  FIRST_SQUARE  = SQ_WIDTH'(9);

    // control from the sequencer to the remainder unit
    typedef struct packed {
        logic start;
    } rem_ctrl_t;

    // status from the remainder unit back to the sequencer
    typedef struct packed {
        logic done;
        logic zero;
    } rem_stat_t;

endpackage

// ===== rtl/trial_division_prime_test_unit.sv =====
// channel  | direction | ports                        | contents
// s_       | in        | s_tvalid s_tready s_tdata    | candidate
// m_       | out       | m_tvalid m_tready m_tdata    | is_prime
//
// one candidate at a time: s_tready is high only while no item is in work
// each odd divisor takes one bound check, VALUE_WIDTH remainder steps in
// tdp_rem_unit and one done strobe; the worst case for a 31-bit prime is
// about 23000 divisors
// values below 4 and even values answer in the cycle after the transfer
// reset (aresetn low, synchronous) returns to idle; a result held on m_
// waits for m_tready and stalls further input until taken
//
// top level of the trial division prime test; depends on tdp_pkg and
// tdp_rem_unit
module trial_division_prime_test_unit
    import tdp_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [S_TDATA_WIDTH-1:0] s_tdata,   // [30:0] candidate, rest zero
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [M_TDATA_WIDTH-1:0] m_tdata    // [0] is_prime, rest zero
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_CHECK  = 4'b0010,
        ST_DIVIDE = 4'b0100,
        ST_RESULT = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic [VALUE_WIDTH-1:0] value_reg, value_next;
    logic [DIV_WIDTH-1:0]   divisor_reg, divisor_next;
    logic [SQ_WIDTH-1:0]    square_reg, square_next;
    logic                   prime_reg, prime_next;
    logic [VALUE_WIDTH-1:0] candidate;
    logic                   s_xfer;
    logic                   m_xfer;
    logic                   beyond_bound;
    logic [SQ_WIDTH-1:0]    square_step;
    rem_ctrl_t              rem_ctrl;
    rem_stat_t              rem_stat;

    assign candidate = s_tdata[VALUE_WIDTH-1:0];
    assign s_xfer    = s_tvalid && s_tready;
    assign m_xfer    = m_tvalid && m_tready;

    // square of the next odd divisor: (d+2)^2 = d^2 + 4d + 4
    assign square_step  = SQ_WIDTH'({divisor_reg, 2'b00}) + SQ_WIDTH'(4);
    assign beyond_bound = square_reg > SQ_WIDTH'(value_reg);

    tdp_rem_unit u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (rem_ctrl),
        .dividend (value_reg),
        .divisor  (divisor_reg),
        .stat     (rem_stat)
    );

    // sequencer
    always_comb begin
        state_next     = state_reg;
        value_next     = value_reg;
        divisor_next   = divisor_reg;
        square_next    = square_reg;
        prime_next     = prime_reg;
        rem_ctrl.start = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    value_next   = candidate;
                    divisor_next = FIRST_DIVISOR;
                    square_next  = FIRST_SQUARE;
                    if (candidate < VALUE_WIDTH'(2)) begin
                        prime_next = 1'b0;
                        state_next = ST_RESULT;
                    end else if (candidate inside {VALUE_WIDTH'(2), VALUE_WIDTH'(3)}) begin
                        prime_next = 1'b1;
                        state_next = ST_RESULT;
                    end else if (!candidate[0]) begin
                        prime_next = 1'b0;
                        state_next = ST_RESULT;
                    end else begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                // no divisor found up to the square root
                if (beyond_bound) begin
                    prime_next = 1'b1;
                    state_next = ST_RESULT;
                end else begin
                    rem_ctrl.start = 1'b1;
                    state_next     = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (rem_stat.done) begin
                    if (rem_stat.zero) begin
                        prime_next = 1'b0;
                        state_next = ST_RESULT;
                    end else begin
                        divisor_next = divisor_reg + DIV_WIDTH'(2);
                        square_next  = square_reg + square_step;
                        state_next   = ST_CHECK;
                    end
                end
            end
            ST_RESULT: begin
                if (m_xfer) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        value_reg   <= value_next;
        divisor_reg <= divisor_next;
        square_reg  <= square_next;
        prime_reg   <= prime_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_RESULT);
    assign m_tdata  = {{(M_TDATA_WIDTH-1){1'b0}}, prime_reg};

endmodule

// ===== rtl/tdp_rem_unit.sv =====
// bit-serial restoring remainder unit, one dividend bit per cycle
// depends on tdp_pkg
module tdp_rem_unit
    import tdp_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  rem_ctrl_t              ctrl,
    input  logic [VALUE_WIDTH-1:0] dividend,
    input  logic [DIV_WIDTH-1:0]   divisor,
    output rem_stat_t              stat
);

    logic [VALUE_WIDTH-1:0] shift_reg, shift_next;
    logic [DIV_WIDTH-1:0]   rem_reg, rem_next;
    logic [CNT_WIDTH-1:0]   cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [DIV_WIDTH:0]     trial;
    logic [DIV_WIDTH:0]     diff;

    // shift in the next dividend bit and try a subtract
    assign trial = {rem_reg, shift_reg[VALUE_WIDTH-1]};
    assign diff  = trial - {1'b0, divisor};

    always_comb begin
        shift_next = shift_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (ctrl.start) begin
            shift_next = dividend;
            rem_next   = '0;
            cnt_next   = CNT_WIDTH'(VALUE_WIDTH - 1);
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            shift_next = {shift_reg[VALUE_WIDTH-2:0], 1'b0};
            // remainder stays below the divisor, so the low bits hold it
            if (trial >= {1'b0, divisor}) begin
                rem_next = diff[DIV_WIDTH-1:0];
            end else begin
                rem_next = trial[DIV_WIDTH-1:0];
            end
            cnt_next = cnt_reg - CNT_WIDTH'(1);
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
    end

    assign stat.done = done_reg;
    assign stat.zero = (rem_reg == '0);

endmodule

// ===== rtl/tdp_checker.sv =====
// port-level checks for the trial division prime test unit
// depends on tdp_pkg; bound to trial_division_prime_test_unit below
module tdp_checker
    import tdp_pkg::*;
(
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_tvalid,
    input logic                     s_tready,
    input logic [S_TDATA_WIDTH-1:0] s_tdata,
    input logic                     m_tvalid,
    input logic                     m_tready,
    input logic [M_TDATA_WIDTH-1:0] m_tdata
);

    // never takes input while a result is pending
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while result pending");

    // input closes right after a transfer
    a_busy_after_in: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input still ready after transfer");

    // even values other than two give a not-prime answer on the next cycle
    a_even_fast: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !s_tdata[0] &&
         s_tdata[VALUE_WIDTH-1:0] != VALUE_WIDTH'(2))
        |=> (m_tvalid && !m_tdata[0]))
        else $error("even candidate not answered as composite");

    // a stalled result holds
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

    // after the result transfer the block is ready again
    a_ready_after_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready) |=> (s_tready && !m_tvalid))
        else $error("not idle after result transfer");

endmodule

bind trial_division_prime_test_unit tdp_checker u_tdp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/trial_division_prime_test_unit_test.sv =====
// self-checking testbench for trial_division_prime_test_unit
// depends on tdp_pkg and the rtl of the block; a scoreboard class predicts each verdict
`timescale 1ns / 1ps

module trial_division_prime_test_unit_test;
    import tdp_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 4_000_000;
    localparam int unsigned LONG_HOLD      = 500;
    localparam int unsigned SETTLE_CYCLES  = 60;
    localparam int unsigned RANDOM_ITEMS   = 80;

    // expected verdicts in transfer order, predicted by trial division
    class primality_scoreboard;
        typedef struct {
            logic [VALUE_WIDTH-1:0] candidate;
            bit                     is_prime;
        } verdict_t;

        verdict_t    awaited[$];
        int unsigned failures;
        int unsigned checked;
        int unsigned primes;
        int unsigned noted;

        function bit trial_divide(logic [VALUE_WIDTH-1:0] value);
            longint unsigned n;
            longint unsigned d;
            n = value;
            if (n < 2) return 1'b0;
            if (n == 2 || n == 3) return 1'b1;
            if (n % 2 == 0) return 1'b0;
            for (d = 3; d * d <= n; d += 2) begin
                if (n % d == 0) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_candidate(logic [S_TDATA_WIDTH-1:0] word);
            verdict_t v;
            // bits above the field are ignored by the block
            v.candidate = word[VALUE_WIDTH-1:0];
            v.is_prime  = trial_divide(v.candidate);
            awaited     = {awaited, v};
            noted++;
        endfunction

        function void check_result(logic [M_TDATA_WIDTH-1:0] word);
            verdict_t v;
            checked++;
            if (word[0] === 1'b1) primes++;
            if (awaited.size() == 0) begin
                failures++;
                $display("%0t: unexpected result, is_prime %0b with nothing awaited",
                         $time, word[0]);
                return;
            end
            v = awaited.pop_front();
            if (word[0] !== v.is_prime) begin
                failures++;
                $display("%0t: is_prime mismatch for candidate %0d: expected %0b, got %0b",
                         $time, v.candidate, v.is_prime, word[0]);
            end
        endfunction

        function int unsigned outstanding();
            return awaited.size();
        endfunction
    endclass

    logic                     aclk     = 1'b0;
    logic                     aresetn  = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [S_TDATA_WIDTH-1:0] s_tdata  = '0;   // [30:0] candidate, rest zero
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [M_TDATA_WIDTH-1:0] m_tdata;         // [0] is_prime, rest zero

    primality_scoreboard verdicts;
    bit                  steady_rx;
    bit                  long_hold_done;
    int unsigned         idle_cycles = 0;
    logic [S_TDATA_WIDTH-1:0] corner_values[$];

    trial_division_prime_test_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // mostly no gap, sometimes a short one, rarely a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(15, 80);
    endfunction

    // keep trial division short: large values carry a small factor
    function automatic logic [S_TDATA_WIDTH-1:0] pick_candidate();
        int unsigned     r;
        int unsigned     d;
        longint unsigned v;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            v = $urandom_range(0, 65535);
        end else if (r < 65) begin
            v = $urandom_range(65536, 1048575);
        end else if (r < 80) begin
            v = $urandom_range(0, 32'h7fff_ffff);
            v = v - (v % 3);
        end else if (r < 90) begin
            v = $urandom_range(0, 32'h7fff_ffff) & 32'h7fff_fffe;
        end else begin
            // odd squares and near-squares sit right on the divisor bound
            d = 2 * $urandom_range(1, 511) + 1;
            v = (r < 95) ? d * d : d * (d + 2);
        end
        return S_TDATA_WIDTH'(v);
    endfunction

    // hold valid high until the block takes the item
    task automatic offer(input logic [S_TDATA_WIDTH-1:0] word);
        s_tdata  <= word;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        verdicts.note_candidate(word);
    endtask

    task automatic pause(input int unsigned cycles);
        s_tvalid <= 1'b0;
        s_tdata  <= S_TDATA_WIDTH'($urandom);
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (verdicts.outstanding() != 0);
    endtask

    // result channel: random stalls, one long hold-off, steady stretches
    initial begin
        int unsigned stall;
        @(posedge aclk iff aresetn);
        forever begin
            if (!long_hold_done && verdicts.checked >= 3) begin
                long_hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else begin
                stall = steady_rx ? 0 : pick_gap();
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            verdicts.check_result(m_tdata);
        end
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("trial_division_prime_test_unit test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus
    initial begin
        int unsigned gap;
        verdicts    = new();
        corner_values = '{
            32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd25, 32'd49,
            32'd97, 32'd10403, 32'd63001, 32'd65521, 32'd1000003,
            32'd1073741824, 32'd1162261467, 32'd2147483643, 32'd2147483645,
            32'd2147483646, 32'h8000_0061, 32'd2147483647
        };
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // back to back corner values so the block fills during the long hold
        foreach (corner_values[i]) begin
            offer(corner_values[i]);
        end
        drain();

        // random part; the middle stretch runs with no idling on either side
        for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
            steady_rx = (i >= 30 && i < 50);
            gap = steady_rx ? 0 : pick_gap();
            if (gap > 0) pause(gap);
            offer(pick_candidate());
        end
        steady_rx = 1'b0;
        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("covered %0d candidates, %0d answered prime, from 0 and 1 up to 2^31-1",
                 verdicts.noted, verdicts.primes);
        $display("with back-pressure, input gaps and a long receiver hold-off");
        if (verdicts.failures == 0) begin
            $display("trial_division_prime_test_unit test passed");
        end else begin
            $display("trial_division_prime_test_unit test failed");
        end
        $finish;
    end

endmodule

// ===== trial_division_prime_test_unit.f =====
rtl/tdp_pkg.sv
rtl/tdp_rem_unit.sv
rtl/trial_division_prime_test_unit.sv
rtl/tdp_checker.sv
tb/trial_division_prime_test_unit_test.sv
